// ----- rtl/dwsp_pkg.sv -----
`default_nettype none

package dwsp_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS      = 8;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int DUTY_SHIFT     = GAIN_FRAC_BITS + FRAC_BITS;

  // Field widths
  localparam int SPEED_IN_W = 16;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 16;
  localparam int SPEED_W    = 24;
  localparam int ESUM_W     = 32;

  // Stream and config port widths
  localparam int TDATA_W   = 80;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // Shared multiplier: unsigned 16-bit gain (as 17-bit signed) times 33-bit signed
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = ESUM_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // PID accumulator and shifted duty
  localparam int ACC_W = PROD_W + 4;
  localparam int ND_W  = ACC_W - DUTY_SHIFT;

  // Divider
  localparam int QUOT_W = 32;
  localparam int DCNT_W = $clog2(QUOT_W);

  // Saturation limits
  localparam logic [SPEED_W-1:0] S24_MAX = 24'h7F_FFFF;
  localparam logic [SPEED_W-1:0] S24_MIN = 24'h80_0000;
  localparam logic [ESUM_W-1:0]  S32_MAX = 32'h7FFF_FFFF;
  localparam logic [ESUM_W-1:0]  S32_MIN = 32'h8000_0000;

  // Register reset values
  localparam logic [15:0] KP_LEFT_RST   = 16'd3277;
  localparam logic [15:0] KI_LEFT_RST   = 16'd52;
  localparam logic [15:0] KD_LEFT_RST   = 16'd29;
  localparam logic [15:0] KP_RIGHT_RST  = 16'd8929;
  localparam logic [15:0] KI_RIGHT_RST  = 16'd91;
  localparam logic [15:0] KD_RIGHT_RST  = 16'd43;
  localparam logic [15:0] PERIOD_RST    = 16'd3000;
  localparam logic [15:0] CTS_RST       = 16'd6434;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_LEFT  = 8'd0,
    REG_KI_LEFT  = 8'd1,
    REG_KD_LEFT  = 8'd2,
    REG_KP_RIGHT = 8'd3,
    REG_KI_RIGHT = 8'd4,
    REG_KD_RIGHT = 8'd5,
    REG_PERIOD   = 8'd6,
    REG_CTS      = 8'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- rtl/dwsp_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle, unsigned.
module dwsp_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dwsp_pkg::QUOT_W-1:0] dividend_i,
  input  wire logic [15:0]                 divisor_i,
  output logic                             done_o,
  output logic [dwsp_pkg::QUOT_W-1:0]      quotient_o
);
  import dwsp_pkg::*;

  localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(QUOT_W - 1);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [QUOT_W-1:0] quo_q;
  logic [15:0]       rem_q;

  logic [16:0] shifted, diff;
  logic        ge;

  // One trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[QUOT_W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : shifted[15:0];
      quo_q <= {quo_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/dual_wheel_speed_pid_core.sv -----
`default_nettype none

// Dual wheel PID speed controller, one transaction per control tick.
// Input stream (s_axis): target speeds, encoder count deltas and elapsed
// milliseconds for both wheels. Output stream (m_axis): new PWM duties and
// the measured speeds now stored; tuser flags a zero interval (speeds held).
// Config channel (cfg_*): gains, PWM period and counts-to-speed scale, always
// ready; write only while no tick is in flight.
// Each tick runs both wheels in turn through one shared 17x33 multiplier and
// one accumulator, then, unless elapsed_ms is zero, computes each wheel's
// speed with one multiply and the shared 32-step restoring divider.
// s_axis_tready is high only between ticks. A finished result sits in the
// output register until taken; if the receiver stalls, the next tick is still
// accepted, but its result waits in the finish step until that register is free.
// Reset restores the register defaults and clears speeds, errors, integrals
// and duties to zero.
module dual_wheel_speed_pid_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] target_speed_left, [31:16] target_speed_right,
  // [47:32] count_delta_left, [63:48] count_delta_right, [79:64] elapsed_ms
  input  wire logic [dwsp_pkg::TDATA_W-1:0]   s_axis_tdata,
  // Output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] duty_left_us, [31:16] duty_right_us,
  // [55:32] speed_left_meas, [79:56] speed_right_meas
  output logic [dwsp_pkg::TDATA_W-1:0]        m_axis_tdata,
  // [0] zero_interval_flag
  output logic                                m_axis_tuser,
  // Config write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dwsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dwsp_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import dwsp_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_ERR    = 11'b000_0000_0010,
    ST_MP     = 11'b000_0000_0100,
    ST_MI     = 11'b000_0000_1000,
    ST_MD     = 11'b000_0001_0000,
    ST_MACC   = 11'b000_0010_0000,
    ST_DUTY   = 11'b000_0100_0000,
    ST_SMUL   = 11'b000_1000_0000,
    ST_SDIV   = 11'b001_0000_0000,
    ST_SSTORE = 11'b010_0000_0000,
    ST_FIN    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [GAIN_W-1:0] kp_q [2];
  logic [GAIN_W-1:0] ki_q [2];
  logic [GAIN_W-1:0] kd_q [2];
  logic [DUTY_W-1:0] period_q;
  logic [15:0]       cts_q;

  // Loop state
  logic signed [SPEED_W-1:0] speed_q [2];
  logic signed [SPEED_W-1:0] perr_q  [2];
  logic signed [ESUM_W-1:0]  esum_q  [2];
  logic        [DUTY_W-1:0]  duty_q  [2];

  // Captured tick
  logic signed [SPEED_IN_W-1:0] tgt_q [2];
  logic signed [15:0]           cnt_q [2];
  logic        [15:0]           ms_q;
  logic                         w_q;

  // Work registers
  logic signed [SPEED_W-1:0] e_q;
  logic signed [SPEED_W:0]   d_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      div_start_q;
  logic [QUOT_W-1:0]         quot;
  logic                      div_done;

  // Output register
  logic               m_valid_q;
  logic [TDATA_W-1:0] m_data_q;
  logic               m_user_q;

  logic s_acc, m_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_free        = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Error, saturated to 24 bits, and its difference
  logic signed [SPEED_W:0]   e_raw;
  logic signed [SPEED_W-1:0] e_sat;
  logic signed [SPEED_W:0]   d_calc;
  always_comb begin
    e_raw = {{(SPEED_W + 1 - SPEED_IN_W){tgt_q[w_q][SPEED_IN_W-1]}}, tgt_q[w_q]}
          - {speed_q[w_q][SPEED_W-1], speed_q[w_q]};
    if (e_raw[SPEED_W] != e_raw[SPEED_W-1]) begin
      e_sat = e_raw[SPEED_W] ? S24_MIN : S24_MAX;
    end else begin
      e_sat = e_raw[SPEED_W-1:0];
    end
    d_calc = {e_sat[SPEED_W-1], e_sat} - {perr_q[w_q][SPEED_W-1], perr_q[w_q]};
  end

  // Encoder delta magnitude
  logic [15:0] cnt_mag;
  assign cnt_mag = cnt_q[w_q][15] ? (~cnt_q[w_q] + 16'd1) : cnt_q[w_q];

  // Shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MP: begin
        mul_a = {1'b0, kp_q[w_q]};
        mul_b = {{(MUL_B_W - SPEED_W){e_q[SPEED_W-1]}}, e_q};
      end
      ST_MI: begin
        mul_a = {1'b0, ki_q[w_q]};
        mul_b = {esum_q[w_q][ESUM_W-1], esum_q[w_q]};
      end
      ST_MD: begin
        mul_a = {1'b0, kd_q[w_q]};
        mul_b = {{(MUL_B_W - SPEED_W - 1){d_q[SPEED_W]}}, d_q};
      end
      ST_SMUL: begin
        mul_a = {1'b0, cts_q};
        mul_b = {{(MUL_B_W - 16){1'b0}}, cnt_mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Accumulator add
  logic signed [ACC_W-1:0] acc_sum;
  assign acc_sum = acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Duty: floor shift, then clamp to 0..period
  logic [ND_W-1:0]   nd;
  logic [DUTY_W-1:0] duty_new;
  always_comb begin
    nd = acc_q[ACC_W-1:DUTY_SHIFT];
    if (nd[ND_W-1]) begin
      duty_new = '0;
    end else if (nd > {{(ND_W - DUTY_W){1'b0}}, period_q}) begin
      duty_new = period_q;
    end else begin
      duty_new = nd[DUTY_W-1:0];
    end
  end

  // Integral with saturation
  logic [ESUM_W:0]   esum_raw;
  logic [ESUM_W-1:0] esum_new;
  always_comb begin
    esum_raw = {esum_q[w_q][ESUM_W-1], esum_q[w_q]}
             + {{(ESUM_W + 1 - SPEED_W){e_q[SPEED_W-1]}}, e_q};
    if (esum_raw[ESUM_W] != esum_raw[ESUM_W-1]) begin
      esum_new = esum_raw[ESUM_W] ? S32_MIN : S32_MAX;
    end else begin
      esum_new = esum_raw[ESUM_W-1:0];
    end
  end

  // Speed from quotient: restore sign, saturate to 24 bits
  logic [SPEED_W-1:0] speed_new;
  logic [QUOT_W-1:0]  quot_neg;
  always_comb begin
    quot_neg = ~quot + 1'b1;
    if (cnt_q[w_q][15]) begin
      if (quot > {{(QUOT_W - SPEED_W){1'b0}}, S24_MIN}) begin
        speed_new = S24_MIN;
      end else begin
        speed_new = quot_neg[SPEED_W-1:0];
      end
    end else begin
      if (quot > {{(QUOT_W - SPEED_W){1'b0}}, S24_MAX}) begin
        speed_new = S24_MAX;
      end else begin
        speed_new = quot[SPEED_W-1:0];
      end
    end
  end

  dwsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_q[QUOT_W-1:0]),
    .divisor_i  (ms_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_acc) state_d = ST_ERR;
      ST_ERR:    state_d = ST_MP;
      ST_MP:     state_d = ST_MI;
      ST_MI:     state_d = ST_MD;
      ST_MD:     state_d = ST_MACC;
      ST_MACC:   state_d = ST_DUTY;
      ST_DUTY: begin
        if (!w_q) begin
          state_d = ST_ERR;
        end else if (ms_q == '0) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SMUL;
        end
      end
      ST_SMUL:   state_d = ST_SDIV;
      ST_SDIV:   if (div_done) state_d = ST_SSTORE;
      ST_SSTORE: state_d = w_q ? ST_FIN : ST_SMUL;
      ST_FIN:    if (m_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= 1'b0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        speed_q[i] <= '0;
        perr_q[i]  <= '0;
        esum_q[i]  <= '0;
        duty_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == ST_SMUL);
      // Output valid: raised out of the finish step, dropped when taken
      if ((state_q == ST_FIN) && m_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (s_acc) w_q <= 1'b0;
        ST_DUTY: begin
          duty_q[w_q] <= duty_new;
          perr_q[w_q] <= e_q;
          esum_q[w_q] <= esum_new;
          w_q         <= !w_q;
        end
        ST_SSTORE: begin
          speed_q[w_q] <= speed_new;
          w_q          <= !w_q;
        end
        default: ;
      endcase
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          tgt_q[0] <= s_axis_tdata[15:0];
          tgt_q[1] <= s_axis_tdata[31:16];
          cnt_q[0] <= s_axis_tdata[47:32];
          cnt_q[1] <= s_axis_tdata[63:48];
          ms_q     <= s_axis_tdata[79:64];
        end
      end
      ST_ERR: begin
        e_q   <= e_sat;
        d_q   <= d_calc;
        acc_q <= {{(ACC_W - DUTY_W - DUTY_SHIFT){1'b0}}, duty_q[w_q],
                  {DUTY_SHIFT{1'b0}}};
      end
      ST_MP: prod_q <= mul_p;
      ST_MI: begin
        acc_q  <= acc_sum;
        prod_q <= mul_p;
      end
      ST_MD: begin
        acc_q  <= acc_sum;
        prod_q <= mul_p;
      end
      ST_MACC: acc_q  <= acc_sum;
      ST_SMUL: prod_q <= mul_p;
      ST_FIN: begin
        if (m_free) begin
          m_data_q <= {speed_q[1], speed_q[0], duty_q[1], duty_q[0]};
          m_user_q <= (ms_q == '0);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q[0]  <= KP_LEFT_RST;
      ki_q[0]  <= KI_LEFT_RST;
      kd_q[0]  <= KD_LEFT_RST;
      kp_q[1]  <= KP_RIGHT_RST;
      ki_q[1]  <= KI_RIGHT_RST;
      kd_q[1]  <= KD_RIGHT_RST;
      period_q <= PERIOD_RST;
      cts_q    <= CTS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KP_LEFT:  kp_q[0]  <= cfg_data_i;
        REG_KI_LEFT:  ki_q[0]  <= cfg_data_i;
        REG_KD_LEFT:  kd_q[0]  <= cfg_data_i;
        REG_KP_RIGHT: kp_q[1]  <= cfg_data_i;
        REG_KI_RIGHT: ki_q[1]  <= cfg_data_i;
        REG_KD_RIGHT: kd_q[1]  <= cfg_data_i;
        REG_PERIOD:   period_q <= cfg_data_i;
        REG_CTS:      cts_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Assertions

  // A duty update never leaves the duty above the period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUTY) |=> (duty_q[$past(w_q)] <= period_q))
    else $error("duty above pwm period after update");

  // The divider is started only at the head of a speed division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (state_q == ST_SDIV))
    else $error("divider started outside speed division");

  // A result appears only out of the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish step");

  // The divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_SDIV))
    else $error("divider done while not waiting");

endmodule

`default_nettype wire
